>>> hw/rtl/rsc_pkg.sv
`default_nettype none

package rsc_pkg;

  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned ST_W        = 3;
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned QDEPTH      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH    = 3'd0,
    OP_ADD     = 3'd1,
    OP_SUB     = 3'd2,
    OP_MUL     = 3'd3,
    OP_DIV     = 3'd4,
    OP_FINISH  = 3'd5,
    OP_INVALID = 3'd6
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_UNDERFLOW = 3'd2,
    ST_OVERFLOW  = 3'd3,
    ST_DIVZERO   = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    CLS_PUSH,
    CLS_ARITH,
    CLS_FINISH,
    CLS_INVALID
  } cls_e;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_e;

  typedef struct packed {
    cls_e              cls;
    alu_e              alu;
    logic [DATA_W-1:0] operand;
  } tok_t;

  typedef struct packed {
    logic            busy;
    logic [SP_W-1:0] depth;
  } stat_t;

endpackage

`default_nettype wire

>>> hw/rtl/rsc_if.sv
`default_nettype none

interface rsc_tok_if;
  logic                                valid;
  logic                                ready;
  logic        [rsc_pkg::OP_W-1:0]     op;
  logic signed [rsc_pkg::DATA_W-1:0]   operand;

  modport source (output valid, output op, output operand, input ready);
  modport sink   (input valid, input op, input operand, output ready);
endinterface

interface rsc_res_if;
  logic                                valid;
  logic                                ready;
  logic signed [rsc_pkg::DATA_W-1:0]   value;
  logic        [rsc_pkg::ST_W-1:0]     status;

  modport source (output valid, output value, output status, input ready);
  modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/rpn_stack_calculator_top.sv
// Reverse-Polish integer calculator with a bounded stack.
// tok_i takes one token per beat: op (push, add, sub, mul, div, finish,
// invalid) and a signed 32-bit operand used by push only. res_o returns
// one beat per finish token and per error: value and status.
// A token passes a front register and a two-entry queue before the
// execute stage takes it; the queue lets tokens keep arriving while the
// execute stage is busy.
// In the execute stage, push and the errors found at issue finish in the
// idle state; add, sub, mul, finish and div pass the read state (stack
// read, then write, result or divide by zero), and div then waits in the
// divide state: the radix-2 divider retires one quotient bit per cycle.
// Reset clears the stack depth, the queue and the output register; the
// stack memory itself is not cleared and needs no clearing pass.
// When the receiver stalls, the result beat holds in the output register;
// the execute stage takes no further token until that slot frees, and
// tok_i stalls once the queue and front register fill.
`default_nettype none

module rpn_stack_calculator_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  rsc_tok_if.sink   tok_i,
  rsc_res_if.source res_o
);

  logic           q_in_valid;
  logic           q_in_ready;
  rsc_pkg::tok_t  q_in_tok;
  logic           q_out_valid;
  logic           q_out_ready;
  rsc_pkg::tok_t  q_out_tok;
  rsc_pkg::stat_t stat;

  rsc_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_i     (tok_i),
    .q_valid_o (q_in_valid),
    .q_ready_i (q_in_ready),
    .q_tok_o   (q_in_tok)
  );

  rsc_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (q_in_valid),
    .in_ready_o  (q_in_ready),
    .in_tok_i    (q_in_tok),
    .out_valid_o (q_out_valid),
    .out_ready_i (q_out_ready),
    .out_tok_o   (q_out_tok)
  );

  rsc_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_out_valid),
    .q_ready_o (q_out_ready),
    .q_tok_i   (q_out_tok),
    .res_o     (res_o),
    .stat_o    (stat)
  );

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.depth <= rsc_pkg::SP_W'(rsc_pkg::STACK_DEPTH))
    else $error("stack depth beyond capacity");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_out_valid && q_out_ready && q_out_tok.cls == rsc_pkg::CLS_PUSH &&
     stat.depth != rsc_pkg::SP_W'(rsc_pkg::STACK_DEPTH))
    |=> stat.depth == $past(stat.depth) + rsc_pkg::SP_W'(1))
    else $error("push did not grow the stack");

  a_invalid_reports: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_out_valid && q_out_ready && q_out_tok.cls == rsc_pkg::CLS_INVALID)
    |=> res_o.valid && res_o.status == rsc_pkg::ST_INVALID)
    else $error("invalid token not reported");

  a_no_issue_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.busy |-> !q_out_ready)
    else $error("token taken while execute stage busy");

endmodule

`default_nettype wire

>>> hw/rtl/rsc_front.sv
`default_nettype none

module rsc_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  rsc_tok_if.sink            tok_i,
  output      logic          q_valid_o,
  input  wire logic          q_ready_i,
  output      rsc_pkg::tok_t q_tok_o
);

  logic          vld_q;
  rsc_pkg::tok_t tok_q;
  rsc_pkg::tok_t tok_d;

  assign tok_i.ready = !vld_q || q_ready_i;
  assign q_valid_o   = vld_q;
  assign q_tok_o     = tok_q;

  always_comb begin
    tok_d.operand = tok_i.operand;
    tok_d.alu     = rsc_pkg::ALU_ADD;
    unique case (tok_i.op)
      rsc_pkg::OP_PUSH: begin
        tok_d.cls = rsc_pkg::CLS_PUSH;
      end
      rsc_pkg::OP_ADD: begin
        tok_d.cls = rsc_pkg::CLS_ARITH;
        tok_d.alu = rsc_pkg::ALU_ADD;
      end
      rsc_pkg::OP_SUB: begin
        tok_d.cls = rsc_pkg::CLS_ARITH;
        tok_d.alu = rsc_pkg::ALU_SUB;
      end
      rsc_pkg::OP_MUL: begin
        tok_d.cls = rsc_pkg::CLS_ARITH;
        tok_d.alu = rsc_pkg::ALU_MUL;
      end
      rsc_pkg::OP_DIV: begin
        tok_d.cls = rsc_pkg::CLS_ARITH;
        tok_d.alu = rsc_pkg::ALU_DIV;
      end
      rsc_pkg::OP_FINISH: begin
        tok_d.cls = rsc_pkg::CLS_FINISH;
      end
      default: begin
        tok_d.cls = rsc_pkg::CLS_INVALID;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      tok_q <= '0;
    end else if (tok_i.valid && tok_i.ready) begin
      vld_q <= 1'b1;
      tok_q <= tok_d;
    end else if (q_ready_i) begin
      vld_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rsc_queue.sv
`default_nettype none

module rsc_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire rsc_pkg::tok_t in_tok_i,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      rsc_pkg::tok_t out_tok_o
);

  localparam int unsigned QAW = (rsc_pkg::QDEPTH > 1) ? $clog2(rsc_pkg::QDEPTH) : 1;
  localparam int unsigned QCW = $clog2(rsc_pkg::QDEPTH + 1);

  rsc_pkg::tok_t    slot_q [rsc_pkg::QDEPTH];
  logic [QAW-1:0]   wptr_q;
  logic [QAW-1:0]   rptr_q;
  logic [QCW-1:0]   cnt_q;
  logic             push;
  logic             pop;

  assign in_ready_o  = cnt_q != QCW'(rsc_pkg::QDEPTH);
  assign out_valid_o = cnt_q != '0;
  assign out_tok_o   = slot_q[rptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= in_tok_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push) begin
        wptr_q <= (wptr_q == QAW'(rsc_pkg::QDEPTH - 1)) ? '0 : wptr_q + QAW'(1);
      end
      if (pop) begin
        rptr_q <= (rptr_q == QAW'(rsc_pkg::QDEPTH - 1)) ? '0 : rptr_q + QAW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QCW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QCW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rsc_div.sv
`default_nettype none

module rsc_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [rsc_pkg::DATA_W-1:0] dividend_i,
  input  wire logic [rsc_pkg::DATA_W-1:0] divisor_i,
  output      logic                       done_o,
  output      logic [rsc_pkg::DATA_W-1:0] quotient_o
);

  localparam int unsigned W   = rsc_pkg::DATA_W;
  localparam int unsigned STW = $clog2(W);

  typedef enum logic [1:0] {
    D_IDLE,
    D_RUN,
    D_DONE
  } dstate_e;

  dstate_e        state_q;
  logic [STW-1:0] step_q;
  logic [W-1:0]   rem_q;
  logic [W-1:0]   quo_q;
  logic [W-1:0]   dvs_q;
  logic           neg_q;
  logic [W:0]     shifted;
  logic [W:0]     diff;

  assign shifted    = {rem_q, quo_q[W-1]};
  assign diff       = shifted - {1'b0, dvs_q};
  assign done_o     = state_q == D_DONE;
  assign quotient_o = neg_q ? (~quo_q + W'(1)) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      step_q  <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
      dvs_q   <= '0;
      neg_q   <= 1'b0;
    end else begin
      unique case (state_q)
        D_IDLE: begin
          if (start_i) begin
            quo_q   <= dividend_i[W-1] ? (~dividend_i + W'(1)) : dividend_i;
            dvs_q   <= divisor_i[W-1] ? (~divisor_i + W'(1)) : divisor_i;
            neg_q   <= dividend_i[W-1] ^ divisor_i[W-1];
            rem_q   <= '0;
            step_q  <= '0;
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          if (!diff[W]) begin
            rem_q <= diff[W-1:0];
            quo_q <= {quo_q[W-2:0], 1'b1};
          end else begin
            rem_q <= shifted[W-1:0];
            quo_q <= {quo_q[W-2:0], 1'b0};
          end
          step_q <= step_q + STW'(1);
          if (step_q == STW'(W - 1)) begin
            state_q <= D_DONE;
          end
        end
        D_DONE: begin
          state_q <= D_IDLE;
        end
        default: begin
          state_q <= D_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/rsc_back.sv
`default_nettype none

module rsc_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          q_valid_i,
  output      logic          q_ready_o,
  input  wire rsc_pkg::tok_t q_tok_i,
  rsc_res_if.source          res_o,
  output      rsc_pkg::stat_t stat_o
);

  localparam int unsigned W  = rsc_pkg::DATA_W;
  localparam int unsigned SW = rsc_pkg::SP_W;
  localparam int unsigned AW = rsc_pkg::ADDR_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_DIV
  } state_e;

  state_e            state_q, state_d;
  logic [SW-1:0]     cnt_q, cnt_d;
  rsc_pkg::tok_t     cur_q, cur_d;
  logic              ovld_q, ovld_d;
  logic [W-1:0]      oval_q, oval_d;
  rsc_pkg::status_e  ost_q, ost_d;

  logic [W-1:0]      mem [rsc_pkg::STACK_DEPTH];
  logic [W-1:0]      rd0_q;
  logic [W-1:0]      rd1_q;
  logic [SW-1:0]     sp_m1;
  logic [SW-1:0]     sp_m2;
  logic [AW-1:0]     raddr0;
  logic [AW-1:0]     raddr1;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [W-1:0]      wdata;
  logic [W-1:0]      prod;
  logic              out_free;
  logic              div_start;
  logic              div_done;
  logic [W-1:0]      div_quo;

  assign sp_m1    = cnt_q - SW'(1);
  assign sp_m2    = cnt_q - SW'(2);
  assign raddr0   = sp_m1[AW-1:0];
  assign raddr1   = sp_m2[AW-1:0];
  assign prod     = rd1_q * rd0_q;
  assign out_free = !ovld_q || res_o.ready;

  assign q_ready_o    = (state_q == S_IDLE) && out_free;
  assign res_o.valid  = ovld_q;
  assign res_o.value  = oval_q;
  assign res_o.status = ost_q;
  assign stat_o.busy  = state_q != S_IDLE;
  assign stat_o.depth = cnt_q;

  rsc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (rd1_q),
    .divisor_i  (rd0_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cur_d     = cur_q;
    ovld_d    = ovld_q && !res_o.ready;
    oval_d    = oval_q;
    ost_d     = ost_q;
    we        = 1'b0;
    waddr     = raddr1;
    wdata     = div_quo;
    div_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (q_valid_i && q_ready_o) begin
          cur_d = q_tok_i;
          unique case (q_tok_i.cls)
            rsc_pkg::CLS_PUSH: begin
              if (cnt_q == SW'(rsc_pkg::STACK_DEPTH)) begin
                ovld_d = 1'b1;
                oval_d = '0;
                ost_d  = rsc_pkg::ST_OVERFLOW;
              end else begin
                we    = 1'b1;
                waddr = cnt_q[AW-1:0];
                wdata = q_tok_i.operand;
                cnt_d = cnt_q + SW'(1);
              end
            end
            rsc_pkg::CLS_FINISH: begin
              if (cnt_q == '0) begin
                ovld_d = 1'b1;
                oval_d = '0;
                ost_d  = rsc_pkg::ST_UNDERFLOW;
              end else begin
                state_d = S_READ;
              end
            end
            rsc_pkg::CLS_ARITH: begin
              if (cnt_q < SW'(2)) begin
                ovld_d = 1'b1;
                oval_d = '0;
                ost_d  = rsc_pkg::ST_UNDERFLOW;
              end else begin
                state_d = S_READ;
              end
            end
            default: begin
              ovld_d = 1'b1;
              oval_d = '0;
              ost_d  = rsc_pkg::ST_INVALID;
            end
          endcase
        end
      end
      S_READ: begin
        state_d = S_IDLE;
        if (cur_q.cls == rsc_pkg::CLS_FINISH) begin
          ovld_d = 1'b1;
          oval_d = rd0_q;
          ost_d  = rsc_pkg::ST_OK;
          cnt_d  = sp_m1;
        end else begin
          unique case (cur_q.alu)
            rsc_pkg::ALU_ADD: begin
              we    = 1'b1;
              wdata = rd1_q + rd0_q;
              cnt_d = sp_m1;
            end
            rsc_pkg::ALU_SUB: begin
              we    = 1'b1;
              wdata = rd1_q - rd0_q;
              cnt_d = sp_m1;
            end
            rsc_pkg::ALU_MUL: begin
              we    = 1'b1;
              wdata = prod;
              cnt_d = sp_m1;
            end
            default: begin
              if (rd0_q == '0) begin
                ovld_d = 1'b1;
                oval_d = '0;
                ost_d  = rsc_pkg::ST_DIVZERO;
              end else begin
                div_start = 1'b1;
                state_d   = S_DIV;
              end
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_done) begin
          we      = 1'b1;
          wdata   = div_quo;
          cnt_d   = sp_m1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd0_q <= mem[raddr0];
    rd1_q <= mem[raddr1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      cur_q   <= '0;
      ovld_q  <= 1'b0;
      oval_q  <= '0;
      ost_q   <= rsc_pkg::ST_OK;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      cur_q   <= cur_d;
      ovld_q  <= ovld_d;
      oval_q  <= oval_d;
      ost_q   <= ost_d;
    end
  end

endmodule

`default_nettype wire

>>> sim/rpn_stack_calculator_top_tb.sv
`default_nettype none

module rpn_stack_calculator_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CTX_GEN = 0;
  localparam int CTX_CHK = 1;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned QUIET_FROM = 1500;
  localparam int unsigned QUIET_TO = 4500;
  localparam int unsigned HOLD_AFTER_BEATS = 150;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 60;

  typedef struct {
    bit                         drain;
    logic [rsc_pkg::OP_W-1:0]   op;
    logic [rsc_pkg::DATA_W-1:0] operand;
  } tok_item_t;

  typedef struct {
    logic [rsc_pkg::DATA_W-1:0] value;
    rsc_pkg::status_e           status;
  } calc_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                              tok_valid = 1'b0;
  logic [rsc_pkg::OP_W-1:0]          tok_op = '0;
  logic signed [rsc_pkg::DATA_W-1:0] tok_operand = '0;
  logic                              res_ready = 1'b0;

  rsc_tok_if tok ();
  rsc_res_if res ();

  assign tok.valid   = tok_valid;
  assign tok.op      = tok_op;
  assign tok.operand = tok_operand;
  assign res.ready   = res_ready;

  rpn_stack_calculator_top dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .tok_i  (tok),
    .res_o  (res)
  );

  always #5ns clk = ~clk;

  logic [rsc_pkg::DATA_W-1:0] stk_mem [2][rsc_pkg::STACK_DEPTH];
  int unsigned                stk_cnt [2] = '{0, 0};

  tok_item_t    tok_pending_q [$];
  calc_result_t calc_results_q [$];

  int unsigned cyc = 0;
  int unsigned idle_run = 0;
  int unsigned res_beats = 0;
  int unsigned fail_count = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          draining = 1'b0;
  bit          tok_fire = 1'b0;
  bit          res_fire = 1'b0;
  bit          got_res;
  calc_result_t exp_res;
  tok_item_t    drv_item;
  logic         quiet;

  assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

  function automatic void rpn_eval(input int ctx, input logic [rsc_pkg::OP_W-1:0] op,
                                   input logic [rsc_pkg::DATA_W-1:0] operand,
                                   output bit emits, output calc_result_t r);
    logic [rsc_pkg::DATA_W-1:0] lhs, rhs, lmag, rmag, acc;
    int unsigned n;
    n = stk_cnt[ctx];
    emits = 1'b1;
    r.value = '0;
    r.status = rsc_pkg::ST_OK;
    lhs = '0;
    rhs = '0;
    acc = '0;
    if (n >= 2) begin
      rhs = stk_mem[ctx][n-1];
      lhs = stk_mem[ctx][n-2];
    end
    case (op)
      rsc_pkg::OP_PUSH: begin
        if (n >= rsc_pkg::STACK_DEPTH) begin
          r.status = rsc_pkg::ST_OVERFLOW;
        end else begin
          stk_mem[ctx][n] = operand;
          stk_cnt[ctx] = n + 1;
          emits = 1'b0;
        end
      end
      rsc_pkg::OP_FINISH: begin
        if (n == 0) begin
          r.status = rsc_pkg::ST_UNDERFLOW;
        end else begin
          stk_cnt[ctx] = n - 1;
          r.value = stk_mem[ctx][n-1];
        end
      end
      rsc_pkg::OP_ADD, rsc_pkg::OP_SUB, rsc_pkg::OP_MUL, rsc_pkg::OP_DIV: begin
        if (n < 2) begin
          r.status = rsc_pkg::ST_UNDERFLOW;
        end else if (op == rsc_pkg::OP_DIV && rhs == '0) begin
          r.status = rsc_pkg::ST_DIVZERO;
        end else begin
          case (op)
            rsc_pkg::OP_ADD: acc = lhs + rhs;
            rsc_pkg::OP_SUB: acc = lhs - rhs;
            rsc_pkg::OP_MUL: acc = lhs * rhs;
            default: begin
              lmag = lhs[rsc_pkg::DATA_W-1] ? -lhs : lhs;
              rmag = rhs[rsc_pkg::DATA_W-1] ? -rhs : rhs;
              acc = lmag / rmag;
              if (lhs[rsc_pkg::DATA_W-1] ^ rhs[rsc_pkg::DATA_W-1]) acc = -acc;
            end
          endcase
          stk_mem[ctx][n-2] = acc;
          stk_cnt[ctx] = n - 1;
          emits = 1'b0;
        end
      end
      default: r.status = rsc_pkg::ST_INVALID;
    endcase
  endfunction

  function automatic void queue_token(input logic [rsc_pkg::OP_W-1:0] op,
                                      input logic [rsc_pkg::DATA_W-1:0] operand);
    bit emits;
    calc_result_t r;
    tok_pending_q.push_back('{1'b0, op, operand});
    rpn_eval(CTX_GEN, op, operand, emits, r);
  endfunction

  function automatic logic [rsc_pkg::DATA_W-1:0] rand_operand();
    int unsigned pick;
    logic [rsc_pkg::DATA_W-1:0] v;
    pick = $urandom_range(7);
    if (pick == 0) begin
      case ($urandom_range(4))
        0: v = '0;
        1: v = 32'd1;
        2: v = '1;
        3: v = 32'h7FFF_FFFF;
        default: v = 32'h8000_0000;
      endcase
    end else if (pick <= 3) begin
      v = $urandom_range(200) - 32'd100;
    end else begin
      v = $urandom();
    end
    return v;
  endfunction

  function automatic logic [rsc_pkg::OP_W-1:0] rand_arith_op();
    return rsc_pkg::OP_W'($urandom_range(rsc_pkg::OP_DIV, rsc_pkg::OP_ADD));
  endfunction

  task automatic queue_random_tokens(input int count);
    int k;
    int unsigned r, n;
    bit filling;
    filling = 1'b0;
    for (k = 0; k < count; k++) begin
      n = stk_cnt[CTX_GEN];
      r = $urandom_range(99);
      if (filling) begin
        if (n >= rsc_pkg::STACK_DEPTH) filling = 1'b0;
        queue_token(rsc_pkg::OP_PUSH, rand_operand());
      end else if (r < 3) begin
        filling = 1'b1;
        queue_token(rsc_pkg::OP_PUSH, rand_operand());
      end else if (r < 7) begin
        queue_token(rsc_pkg::OP_W'($urandom_range(7)), $urandom());
      end else if (n < 2) begin
        if (r < 80) queue_token(rsc_pkg::OP_PUSH, rand_operand());
        else if (r < 92) queue_token(rsc_pkg::OP_FINISH, $urandom());
        else queue_token(rand_arith_op(), $urandom());
      end else begin
        if (r < 40 && n < rsc_pkg::STACK_DEPTH) queue_token(rsc_pkg::OP_PUSH, rand_operand());
        else if (r < 88) queue_token(rand_arith_op(), $urandom());
        else queue_token(rsc_pkg::OP_FINISH, $urandom());
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      cyc++;
      tok_fire = tok.valid && tok.ready;
      res_fire = res.valid && res.ready;
      if (tok_fire) begin
        rpn_eval(CTX_CHK, tok.op, tok.operand, got_res, exp_res);
        if (got_res) calc_results_q.push_back(exp_res);
      end
      if (res_fire) begin
        res_beats++;
        if (calc_results_q.size() == 0) begin
          $error("unexpected result beat: value %0d, status %0d", res.value, res.status);
          fail_count++;
        end else begin
          exp_res = calc_results_q.pop_front();
          if (res.value !== exp_res.value) begin
            $error("value: expected %0d, got %0d", $signed(exp_res.value), res.value);
            fail_count++;
          end
          if (res.status !== exp_res.status) begin
            $error("status: expected %0d, got %0d", exp_res.status, res.status);
            fail_count++;
          end
        end
      end
      idle_run = (tok_fire || res_fire) ? 0 : idle_run + 1;
    end
  end

  always @(negedge clk) begin
    if (rst_n && !(tok_valid && !tok_fire)) begin
      if (draining) begin
        tok_valid <= 1'b0;
        if (calc_results_q.size() == 0) draining = 1'b0;
      end else if (tok_pending_q.size() == 0 || (!quiet && $urandom_range(99) < 10)) begin
        tok_valid <= 1'b0;
      end else begin
        drv_item = tok_pending_q.pop_front();
        if (drv_item.drain) begin
          draining = 1'b1;
          tok_valid <= 1'b0;
        end else begin
          tok_valid   <= 1'b1;
          tok_op      <= drv_item.op;
          tok_operand <= drv_item.operand;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else if (!hold_done && res_beats >= HOLD_AFTER_BEATS) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      res_ready <= 1'b0;
    end else begin
      res_ready <= quiet || ($urandom_range(99) >= 10);
    end
  end

  initial begin
    while (idle_run < WATCHDOG_LIMIT) @(negedge clk);
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    queue_token(rsc_pkg::OP_FINISH, $urandom());
    queue_token(rsc_pkg::OP_PUSH, 32'h7FFF_FFFF);
    queue_token(rsc_pkg::OP_ADD, $urandom());
    queue_token(rsc_pkg::OP_PUSH, 32'd1);
    queue_token(rsc_pkg::OP_ADD, $urandom());
    queue_token(rsc_pkg::OP_PUSH, '1);
    queue_token(rsc_pkg::OP_DIV, $urandom());
    queue_token(rsc_pkg::OP_PUSH, '0);
    queue_token(rsc_pkg::OP_DIV, $urandom());
    queue_token(rsc_pkg::OP_FINISH, $urandom());
    queue_token(rsc_pkg::OP_FINISH, $urandom());
    queue_token(rsc_pkg::OP_PUSH, 32'h8000_0000);
    queue_token(rsc_pkg::OP_FINISH, $urandom());
    queue_token(rsc_pkg::OP_PUSH, -32'sd7);
    queue_token(rsc_pkg::OP_PUSH, 32'd2);
    queue_token(rsc_pkg::OP_DIV, $urandom());
    queue_token(rsc_pkg::OP_PUSH, 32'd3);
    queue_token(rsc_pkg::OP_MUL, $urandom());
    queue_token(rsc_pkg::OP_PUSH, 32'd10);
    queue_token(rsc_pkg::OP_SUB, $urandom());
    queue_token(rsc_pkg::OP_INVALID, $urandom());
    queue_token(3'd7, $urandom());
    queue_token(rsc_pkg::OP_FINISH, $urandom());
    queue_random_tokens(800);
    tok_pending_q.push_back('{1'b1, '0, '0});
    queue_random_tokens(800);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (tok_pending_q.size() != 0 || draining || tok_valid || calc_results_q.size() != 0)
      @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

`default_nettype wire
